/* rtl/core/afct_pkg.sv */
// Shared types, constants and helpers for the AABB frustum cull test.
package afct_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COORD_SHIFT = 32 - COORD_WIDTH;
  localparam int NUM_REGS = 8;
  localparam int REG_W = 64;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 8;
  localparam int NUM_CORNERS = 8;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [64:0] psum_t;
  typedef logic signed [65:0] clip_t;
  typedef logic signed [66:0] cmp_t;
  typedef logic [REG_W-1:0] mvp_reg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    coord_t c0;
    coord_t c1;
    coord_t c2;
    coord_t c3;
  } mat_row_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  localparam mvp_reg_t MVP_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // Keep the low COORD_WIDTH bits and sign-extend from the top one.
  function automatic coord_t sext_coord(input logic [31:0] v);
    coord_t t;
    t = coord_t'(v << COORD_SHIFT);
    return t >>> COORD_SHIFT;
  endfunction

  function automatic prod_t mul(input coord_t a, input coord_t b);
    prod_t p;
    p = a * b;
    return p;
  endfunction

endpackage

/* rtl/core/afct_box_if.sv */
// Input channel carrying one box word: min and max corners.
interface afct_box_if;
  logic            valid;
  logic            ready;
  afct_pkg::coord_t box_min_x;
  afct_pkg::coord_t box_min_y;
  afct_pkg::coord_t box_min_z;
  afct_pkg::coord_t box_max_x;
  afct_pkg::coord_t box_max_y;
  afct_pkg::coord_t box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

/* rtl/core/afct_vis_if.sv */
// Result channel carrying one visibility word.
interface afct_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (
    output valid, visible,
    input  ready
  );
  modport sink (
    input  valid, visible,
    output ready
  );
endinterface

/* rtl/core/afct_row.sv */
// One matrix row applied to all eight box corners over three register stages.
module afct_row (
  input  logic                clk,
  input  afct_pkg::stage_en_t en,
  input  afct_pkg::vec3_t     box_lo,
  input  afct_pkg::vec3_t     box_hi,
  input  afct_pkg::mat_row_t  row,
  output afct_pkg::clip_t     clip [afct_pkg::NUM_CORNERS]
);

  afct_pkg::prod_t px_r [2];
  afct_pkg::prod_t py_r [2];
  afct_pkg::prod_t pz_r [2];
  afct_pkg::prod_t wt_r;
  afct_pkg::psum_t sxy_r [4];
  afct_pkg::psum_t szw_r [2];
  afct_pkg::clip_t clip_r [afct_pkg::NUM_CORNERS];

  // Stage 1: the six coordinate products; w is 1.0, so its term is a shift.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      px_r[0] <= afct_pkg::mul(row.c0, box_lo.x);
      px_r[1] <= afct_pkg::mul(row.c0, box_hi.x);
      py_r[0] <= afct_pkg::mul(row.c1, box_lo.y);
      py_r[1] <= afct_pkg::mul(row.c1, box_hi.y);
      pz_r[0] <= afct_pkg::mul(row.c2, box_lo.z);
      pz_r[1] <= afct_pkg::mul(row.c2, box_hi.z);
      wt_r    <= afct_pkg::prod_t'(signed'({row.c3, 16'h0000}));
    end
  end

  // Stage 2: x+y pairs and z+w pairs. Corner bit 0 picks x, bit 1 y, bit 2 z.
  for (genvar i = 0; i < 4; i++) begin : g_sxy
    always_ff @(posedge clk) begin
      if (en.s2) begin
        sxy_r[i] <= afct_pkg::psum_t'(px_r[i & 1]) + afct_pkg::psum_t'(py_r[i >> 1]);
      end
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_szw
    always_ff @(posedge clk) begin
      if (en.s2) begin
        szw_r[j] <= afct_pkg::psum_t'(pz_r[j]) + afct_pkg::psum_t'(wt_r);
      end
    end
  end

  // Stage 3: full clip coordinate of each corner.
  for (genvar k = 0; k < afct_pkg::NUM_CORNERS; k++) begin : g_clip
    always_ff @(posedge clk) begin
      if (en.s3) begin
        clip_r[k] <= afct_pkg::clip_t'(sxy_r[k & 3]) + afct_pkg::clip_t'(szw_r[k >> 2]);
      end
    end
    assign clip[k] = clip_r[k];
  end

endmodule

/* rtl/core/aabb_frustum_cull_test.sv */
// Top level of the AABB frustum cull test pipeline.
//
// Usage: a box word enters on in_box (min and max corners, signed Q16.16)
// and one word leaves on out_vis with visible set when any of the eight
// corners, transformed by the 4x4 matrix, lies strictly inside the clip
// volume -w<x<w, -w<y<w, 0<z<w. Both channels use valid/ready; a word moves
// at a clock edge where both are high. The matrix sits in eight 64-bit
// registers written through cfg_we/cfg_index/cfg_wdata (two Q16.16 entries
// each, lower column in the low half); indexes of 8 and up are dropped.
// Write the matrix only while no box is in flight.
// The path from the accepting edge to out_vis.valid runs through
// five registers: input, multiply, pair sums, corner sums, compare/output.
// Throughput is one box per cycle while out_vis.ready is high, set by the
// fully pipelined multipliers (24 products of 32x32 bits per stage-1 cycle).
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// identity matrix. When the receiver holds ready low, each stage still
// takes a word as long as the stage after it has room, so bubbles close up
// and in_box.ready falls only once all five stages are full.
module aabb_frustum_cull_test (
  input  logic                              clk,
  input  logic                              rst_n,
  afct_box_if.sink                          in_box,
  afct_vis_if.source                        out_vis,
  input  logic                              cfg_we,
  input  logic [afct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  afct_pkg::mvp_reg_t                cfg_wdata
);

  afct_pkg::mvp_reg_t mvp_r [afct_pkg::NUM_REGS];

  logic vld0_r, vld1_r, vld2_r, vld3_r, vld4_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  afct_pkg::vec3_t   lo_r, hi_r;
  afct_pkg::stage_en_t en;
  afct_pkg::clip_t   clip [4][afct_pkg::NUM_CORNERS];
  logic              visible_r;
  logic              visible_nxt;

  // Matrix registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvp_r <= afct_pkg::MVP_RESET;
    end else if (cfg_we && (cfg_index < afct_pkg::CFG_IDX_W'(afct_pkg::NUM_REGS))) begin
      mvp_r[cfg_index[afct_pkg::REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // Per-stage ready: a stage loads when it is empty or its word moves on.
  assign rdy4 = !vld4_r || out_vis.ready;
  assign rdy3 = !vld3_r || rdy4;
  assign rdy2 = !vld2_r || rdy3;
  assign rdy1 = !vld1_r || rdy2;
  assign rdy0 = !vld0_r || rdy1;
  assign in_box.ready = rdy0;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (rdy0) vld0_r <= in_box.valid;
      if (rdy1) vld1_r <= vld0_r;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= vld3_r;
    end
  end

  // Input register, with coordinates narrowed to COORD_WIDTH bits.
  always_ff @(posedge clk) begin
    if (rdy0) begin
      lo_r.x <= afct_pkg::sext_coord(in_box.box_min_x);
      lo_r.y <= afct_pkg::sext_coord(in_box.box_min_y);
      lo_r.z <= afct_pkg::sext_coord(in_box.box_min_z);
      hi_r.x <= afct_pkg::sext_coord(in_box.box_max_x);
      hi_r.y <= afct_pkg::sext_coord(in_box.box_max_y);
      hi_r.z <= afct_pkg::sext_coord(in_box.box_max_z);
    end
  end

  // One transform unit per matrix row; clip[3] carries w.
  for (genvar r = 0; r < 4; r++) begin : g_row
    afct_pkg::mat_row_t row;

    assign row.c0 = afct_pkg::coord_t'(mvp_r[2*r][31:0]);
    assign row.c1 = afct_pkg::coord_t'(mvp_r[2*r][63:32]);
    assign row.c2 = afct_pkg::coord_t'(mvp_r[2*r+1][31:0]);
    assign row.c3 = afct_pkg::coord_t'(mvp_r[2*r+1][63:32]);

    afct_row u_row (
      .clk    (clk),
      .en     (en),
      .box_lo (lo_r),
      .box_hi (hi_r),
      .row    (row),
      .clip   (clip[r])
    );
  end

  // Strict containment of each corner, widened so that -w cannot overflow.
  always_comb begin
    afct_pkg::cmp_t cx, cy, cz, cw, nw;
    visible_nxt = 1'b0;
    for (int k = 0; k < afct_pkg::NUM_CORNERS; k++) begin
      cx = afct_pkg::cmp_t'(clip[0][k]);
      cy = afct_pkg::cmp_t'(clip[1][k]);
      cz = afct_pkg::cmp_t'(clip[2][k]);
      cw = afct_pkg::cmp_t'(clip[3][k]);
      nw = -cw;
      if ((nw < cx) && (cx < cw) && (nw < cy) && (cy < cw) &&
          (cz > afct_pkg::cmp_t'(0)) && (cz < cw)) begin
        visible_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      visible_r <= visible_nxt;
    end
  end

  assign out_vis.valid   = vld4_r;
  assign out_vis.visible = visible_r;

endmodule

/* tb/aabb_frustum_cull_test_tb.sv */
// Self-checking testbench for the AABB frustum cull block: random boxes, matrices and stalls.
module aabb_frustum_cull_test_tb;

  // Register indexes of the matrix, two Q16.16 entries per register.
  localparam int unsigned REG_ROW0_COLS01 = 0;
  localparam int unsigned REG_ROW0_COLS23 = 1;
  localparam int unsigned REG_ROW1_COLS01 = 2;
  localparam int unsigned REG_ROW1_COLS23 = 3;
  localparam int unsigned REG_ROW2_COLS01 = 4;
  localparam int unsigned REG_ROW2_COLS23 = 5;
  localparam int unsigned REG_ROW3_COLS01 = 6;
  localparam int unsigned REG_ROW3_COLS23 = 7;
  // Indexes past the last register; the block must drop these writes.
  localparam int unsigned REG_IDX_PAST_END = 8;
  localparam int unsigned REG_IDX_TOP = 255;

  localparam int LATENCY = 5;
  localparam int RUN_LIMIT = 2_000_000;

  // Handy Q16.16 values.
  localparam int Q_ONE = 32'sh0001_0000;
  localparam int Q_HALF = 32'sh0000_8000;
  localparam int Q_MAX = 32'sh7FFF_FFFF;
  localparam int Q_MIN = 32'sh8000_0000;

  typedef struct {
    afct_pkg::coord_t lo [3];
    afct_pkg::coord_t hi [3];
  } box_t;

  // Keeps a private copy of the matrix, works out the visibility of every
  // accepted box and checks the words that come back, oldest first.
  class vis_scoreboard;
    afct_pkg::mvp_reg_t mvp [afct_pkg::NUM_REGS];
    bit pending_vis [$];
    int errors;

    function new();
      foreach (mvp[i]) mvp[i] = '0;
      // Identity matrix after reset.
      mvp[REG_ROW0_COLS01] = {32'd0, Q_ONE};
      mvp[REG_ROW1_COLS01] = {Q_ONE, 32'd0};
      mvp[REG_ROW2_COLS23] = {32'd0, Q_ONE};
      mvp[REG_ROW3_COLS23] = {Q_ONE, 32'd0};
      errors = 0;
    endfunction

    function void write_reg(int unsigned idx, afct_pkg::mvp_reg_t val);
      if (idx < afct_pkg::NUM_REGS) mvp[idx] = val;
    endfunction

    function logic signed [31:0] entry(int r, int c);
      afct_pkg::mvp_reg_t w;
      w = mvp[r * 2 + c / 2];
      return (c % 2) ? w[63:32] : w[31:0];
    endfunction

    // Coordinates are signed COORD_WIDTH-bit values; bits above are ignored.
    function logic signed [63:0] widen_coord(logic [31:0] v);
      logic signed [63:0] t;
      t = {v << (32 - afct_pkg::COORD_WIDTH), 32'd0};
      return t >>> (64 - afct_pkg::COORD_WIDTH);
    endfunction

    // Products are exact Q32.32 values and the sums are 128 bits wide, so
    // the strict clip-volume comparisons never see an overflow.
    function bit predict_visible(box_t b);
      logic signed [63:0] corner [4];
      logic signed [127:0] clip [4];
      logic signed [127:0] neg_w;
      logic signed [31:0] m;
      bit vis;
      vis = 0;
      for (int k = 0; k < 8; k++) begin
        corner[0] = widen_coord((k & 1) ? b.hi[0] : b.lo[0]);
        corner[1] = widen_coord((k & 2) ? b.hi[1] : b.lo[1]);
        corner[2] = widen_coord((k & 4) ? b.hi[2] : b.lo[2]);
        corner[3] = Q_ONE;
        for (int r = 0; r < 4; r++) begin
          clip[r] = '0;
          for (int c = 0; c < 4; c++) begin
            m = entry(r, c);
            clip[r] = clip[r] + m * corner[c];
          end
        end
        neg_w = -clip[3];
        if (neg_w < clip[0] && clip[0] < clip[3] &&
            neg_w < clip[1] && clip[1] < clip[3] &&
            clip[2] > 0 && clip[2] < clip[3]) vis = 1;
      end
      return vis;
    endfunction

    function void note_box(box_t b);
      pending_vis.push_back(predict_visible(b));
    endfunction

    function int pending();
      return pending_vis.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_vis(logic got);
      bit want;
      if (pending_vis.size() == 0) begin
        report($sformatf("visible word %b arrived with no box outstanding", got));
      end else begin
        want = pending_vis.pop_front();
        if (got !== want) report($sformatf("visible = %b, predicted %b", got, want));
      end
    endtask

    task flag_leftover();
      if (pending_vis.size() != 0)
        report($sformatf("%0d visible words never arrived", pending_vis.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [afct_pkg::CFG_IDX_W-1:0] cfg_index;
  afct_pkg::mvp_reg_t cfg_wdata;

  afct_box_if box_ch ();
  afct_vis_if vis_ch ();

  aabb_frustum_cull_test dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_box   (box_ch),
    .out_vis  (vis_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  vis_scoreboard sb = new();

  // Percent chance, per cycle, that each side holds off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Staged register writes, applied in one burst while the block is idle.
  int unsigned cfg_idx_q [$];
  afct_pkg::mvp_reg_t cfg_val_q [$];
  afct_pkg::mvp_reg_t mvp_next [afct_pkg::NUM_REGS];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit: far above the slowest legal run, even with every word
  // waiting out the longest stalls on both sides.
  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver side. The handshake seen at an edge uses the values from just
  // before that edge; ready for the next cycle is then chosen at random.
  initial begin
    vis_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && vis_ch.valid && vis_ch.ready) sb.check_vis(vis_ch.visible);
      vis_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int rand_signed(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  // Values that sit on or right beside a clip plane, plus the field extremes.
  function automatic int pick_edge();
    case ($urandom_range(9))
      0: return 0;
      1: return Q_ONE;
      2: return -Q_ONE;
      3: return Q_MAX;
      4: return Q_MIN;
      5: return 1;
      6: return -1;
      7: return Q_ONE - 1;
      8: return 1 - Q_ONE;
      default: return Q_HALF;
    endcase
  endfunction

  // Mostly well-formed boxes near the unit cube, so that the visible and the
  // culled outcome both turn up often; the rest are raw bit patterns
  // (min above max included) and values on the clip planes.
  function automatic box_t rand_box();
    box_t b;
    int unsigned sel;
    int unsigned span;
    int ctr;
    int half;
    sel = $urandom_range(9);
    case ($urandom_range(3))
      0: span = 1 << 15;
      3: span = 1 << 21;
      default: span = 1 << 17;
    endcase
    for (int a = 0; a < 3; a++) begin
      if (sel < 2) begin
        b.lo[a] = $urandom;
        b.hi[a] = $urandom;
      end else if (sel < 4) begin
        b.lo[a] = pick_edge();
        b.hi[a] = pick_edge();
      end else begin
        ctr = rand_signed(span);
        half = $urandom_range(span);
        b.lo[a] = ctr - half;
        b.hi[a] = ctr + half;
      end
    end
    return b;
  endfunction

  // Offers one box word and holds it until the block takes it. The box is
  // handed to the scoreboard at the edge where it is accepted.
  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(posedge clk);
    end
    box_ch.valid     <= 1'b1;
    box_ch.box_min_x <= b.lo[0];
    box_ch.box_min_y <= b.lo[1];
    box_ch.box_min_z <= b.lo[2];
    box_ch.box_max_x <= b.hi[0];
    box_ch.box_max_y <= b.hi[1];
    box_ch.box_max_z <= b.hi[2];
    do @(posedge clk); while (!box_ch.ready);
    sb.note_box(b);
  endtask

  task automatic send_coords(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo[0] = lx;
    b.lo[1] = ly;
    b.lo[2] = lz;
    b.hi[0] = hx;
    b.hi[1] = hy;
    b.hi[2] = hz;
    send_box(b);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_box(rand_box());
  endtask

  // Drops valid and waits until every predicted word has come back, then
  // waits out LATENCY plus a margin so the pipeline is surely empty.
  task automatic drain();
    box_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic stage_matrix();
    for (int i = 0; i < afct_pkg::NUM_REGS; i++) begin
      cfg_idx_q.push_back(i);
      cfg_val_q.push_back(mvp_next[i]);
    end
  endtask

  // Writes the staged registers back to back; write enable is raised once
  // and only lowered after the last one.
  task automatic apply_cfg();
    int unsigned idx;
    afct_pkg::mvp_reg_t val;
    while (cfg_idx_q.size() != 0) begin
      idx = cfg_idx_q.pop_front();
      val = cfg_val_q.pop_front();
      cfg_we    <= 1'b1;
      cfg_index <= afct_pkg::CFG_IDX_W'(idx);
      cfg_wdata <= val;
      @(posedge clk);
      sb.write_reg(idx, val);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_matrix(int unsigned span, bit lift_w);
    int lo;
    int hi;
    for (int i = 0; i < afct_pkg::NUM_REGS; i++) begin
      lo = rand_signed(span);
      hi = rand_signed(span);
      mvp_next[i] = {hi, lo};
    end
    // Pulling w toward 1.0 keeps a fair share of boxes inside the volume.
    if (lift_w) mvp_next[REG_ROW3_COLS23][63:32] = Q_ONE + rand_signed(Q_HALF);
  endtask

  initial begin
    // Every input is known from time zero, with reset held low at first.
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    box_ch.valid <= 1'b0;
    box_ch.box_min_x <= '0;
    box_ch.box_min_y <= '0;
    box_ch.box_min_z <= '0;
    box_ch.box_max_x <= '0;
    box_ch.box_max_y <= '0;
    box_ch.box_max_z <= '0;
    send_idle_pct = 20;
    recv_idle_pct = 56;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed boxes against the identity matrix from reset. With identity,
    // the clip test reduces to -1 < x < 1, -1 < y < 1 and 0 < z < 1.
    send_coords(0, 0, 0, 0, 0, 0);                    // z on the near plane
    send_coords(-Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF, Q_HALF);
    send_coords(Q_ONE, 0, Q_HALF, Q_ONE, 0, Q_HALF);  // on the x = w plane
    send_coords(-Q_ONE, 0, Q_HALF, -Q_ONE, 0, Q_HALF);
    send_coords(0, -Q_ONE, Q_HALF, 0, -Q_ONE, Q_HALF);
    send_coords(0, 0, Q_ONE, 0, 0, Q_ONE);            // on the far plane
    send_coords(Q_ONE - 1, 1 - Q_ONE, 1, Q_ONE - 1, 1 - Q_ONE, 1);
    send_coords(0, 0, Q_ONE - 1, 0, 0, Q_ONE - 1);
    // Min above max: corners are built as given, four of them lie inside.
    send_coords(Q_HALF, Q_HALF, Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF);
    send_coords(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_coords(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_coords(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    send_coords(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    // A box that encloses the whole volume still has no corner inside it.
    send_coords(-2 * Q_ONE, -2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 2 * Q_ONE);
    send_coords(0, 0, 0, Q_HALF, Q_HALF, Q_HALF);
    send_random(200);
    drain();

    // Small random matrix with w pulled toward 1.0.
    random_matrix(2 * Q_ONE, 1'b1);
    stage_matrix();
    apply_cfg();
    send_random(200);
    drain();

    // Now the sender is the slow side and the receiver the busy one.
    send_idle_pct = 56;
    recv_idle_pct = 20;

    // Simple perspective: w takes z, and the depth row halves z, so a point
    // is inside when z > 0 and |x|, |y| < z. A write past the last register
    // rides along and must leave the matrix untouched.
    foreach (mvp_next[i]) mvp_next[i] = '0;
    mvp_next[REG_ROW0_COLS01] = {32'd0, Q_ONE};
    mvp_next[REG_ROW1_COLS01] = {Q_ONE, 32'd0};
    mvp_next[REG_ROW2_COLS23] = {32'd0, Q_HALF};
    mvp_next[REG_ROW3_COLS23] = {32'd0, Q_ONE};
    stage_matrix();
    cfg_idx_q.push_back(REG_IDX_PAST_END);
    cfg_val_q.push_back('1);
    apply_cfg();
    send_random(200);
    drain();

    // Extreme entries in every register, including all ones, with another
    // write beyond the register range.
    mvp_next[REG_ROW0_COLS01] = 64'h8000_0000_7FFF_FFFF;
    mvp_next[REG_ROW0_COLS23] = 64'h7FFF_FFFF_8000_0000;
    mvp_next[REG_ROW1_COLS01] = 64'hFFFF_FFFF_FFFF_FFFF;
    mvp_next[REG_ROW1_COLS23] = 64'h8000_0000_8000_0000;
    mvp_next[REG_ROW2_COLS01] = 64'h7FFF_FFFF_7FFF_FFFF;
    mvp_next[REG_ROW2_COLS23] = 64'h0000_0001_FFFF_FFFF;
    mvp_next[REG_ROW3_COLS01] = 64'h8000_0000_0000_0001;
    mvp_next[REG_ROW3_COLS23] = 64'h7FFF_FFFF_7FFF_FFFF;
    stage_matrix();
    cfg_idx_q.push_back(REG_IDX_TOP);
    cfg_val_q.push_back(64'h0000_0000_0000_0000);
    apply_cfg();
    send_random(150);
    drain();

    // Neither side idles from here on.
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // All-zero matrix: w is zero, so nothing can be visible.
    foreach (mvp_next[i]) mvp_next[i] = '0;
    stage_matrix();
    apply_cfg();
    send_random(50);
    drain();

    // Another small random matrix; halfway through, the sender stops until
    // the block has handed back every word it owes.
    random_matrix(Q_ONE, 1'b1);
    stage_matrix();
    apply_cfg();
    send_random(100);
    drain();
    send_random(100);
    drain();

    sb.flag_leftover();
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/afct_pkg.sv
rtl/core/afct_box_if.sv
rtl/core/afct_vis_if.sv
rtl/core/afct_row.sv
rtl/core/aabb_frustum_cull_test.sv
tb/aabb_frustum_cull_test_tb.sv
